### hw/rtl/framed_download_receiver_assert.svh
// Assertion macros used by the framed download receiver core.
`ifndef FRAMED_DOWNLOAD_RECEIVER_ASSERT_SVH
`define FRAMED_DOWNLOAD_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FDR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FDR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/fdr_pkg.sv
// Types, codes and constants of the framed download receiver.
package fdr_pkg;

  // Receiver phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HEAD = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_HDR_BYTE = 3'd1,
    ST_HDR_BAD  = 3'd2,
    ST_PAYLOAD  = 3'd3,
    ST_DONE_OK  = 3'd4,
    ST_DONE_ERR = 3'd5
  } status_t;

  // File kind codes reported at completion
  localparam logic [1:0] KIND_IMAGE   = 2'd0;
  localparam logic [1:0] KIND_IMAGE2  = 2'd1;
  localparam logic [1:0] KIND_FONT    = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  // File kind byte values in the header
  localparam logic [7:0] HDR_KIND_IMAGE  = 8'h02;
  localparam logic [7:0] HDR_KIND_IMAGE2 = 8'h03;
  localparam logic [7:0] HDR_KIND_FONT   = 8'h04;

  // Framing characters
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_D     = 8'h44;  // 'D'
  localparam logic [7:0] CH_F     = 8'h46;  // 'F'
  localparam logic [7:0] CH_6     = 8'h36;  // '6'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'

  localparam logic [23:0] MAX_SIZE_RST = 24'h200000;

  // Header bytes that are kept, and their slot in the capture registers
  localparam int HDR_FIELDS = 13;
  localparam logic [5:0] HDR_IDX [HDR_FIELDS] = '{
    6'd1, 6'd2, 6'd3, 6'd6, 6'd10, 6'd11,
    6'd12, 6'd13, 6'd14, 6'd16, 6'd17, 6'd18, 6'd19
  };
  localparam int F_SIG1 = 0;
  localparam int F_SIG2 = 1;
  localparam int F_SIG3 = 2;
  localparam int F_SIG6 = 3;
  localparam int F_KIND = 4;
  localparam int F_SLOT = 5;
  localparam int F_LEN0 = 6;
  localparam int F_LEN1 = 7;
  localparam int F_LEN2 = 8;
  localparam int F_SUM0 = 9;
  localparam int F_SUM1 = 10;
  localparam int F_SUM2 = 11;
  localparam int F_SUM3 = 12;

  // One result transaction
  typedef struct packed {
    logic [2:0]  status;
    logic        store_valid;
    logic [23:0] store_offset;
    logic [7:0]  store_data;
    logic [1:0]  file_kind;
    logic [7:0]  slot;
    logic [31:0] expected_sum;
    logic [31:0] computed_sum;
  } fdr_result_t;

  // Map the header kind byte to the reported file kind
  function automatic logic [1:0] kind_code(input logic [7:0] b);
    case (b)
      HDR_KIND_IMAGE:  kind_code = KIND_IMAGE;
      HDR_KIND_IMAGE2: kind_code = KIND_IMAGE2;
      HDR_KIND_FONT:   kind_code = KIND_FONT;
      default:         kind_code = KIND_UNKNOWN;
    endcase
  endfunction

endpackage

### hw/rtl/fdr_if.sv
// Channel interfaces of the framed download receiver.
interface fdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fdr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        store_valid;
  logic [23:0] store_offset;
  logic [7:0]  store_data;
  logic [1:0]  file_kind;
  logic [7:0]  slot;
  logic [31:0] expected_sum;
  logic [31:0] computed_sum;

  modport source (output valid, output status, output store_valid, output store_offset,
                  output store_data, output file_kind, output slot, output expected_sum,
                  output computed_sum, input ready);
  modport sink (input valid, input status, input store_valid, input store_offset,
                input store_data, input file_kind, input slot, input expected_sum,
                input computed_sum, output ready);
endinterface

interface fdr_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] max_size;

  modport source (output valid, output max_size, input ready);
  modport sink (input valid, input max_size, output ready);
endinterface

### hw/rtl/fdr_core.sv
// Frame parser: header capture, length and sum tracking, result building.
module fdr_core import fdr_pkg::*; #(
  parameter int HEADER_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_rx_byte,
  input  logic        space_ok,
  input  logic        cfg_valid,
  input  logic [23:0] cfg_max_size,
  output logic        push,
  output fdr_result_t res
);

  `include "framed_download_receiver_assert.svh"

  localparam int CW = $clog2(HEADER_BYTES + 1);
  localparam logic [CW-1:0] LAST = CW'(HEADER_BYTES - 1);

  phase_t      phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [23:0] len_r, len_nxt;
  logic [31:0] hsum_r, hsum_nxt;
  logic [31:0] rsum_r, rsum_nxt;
  logic [23:0] wo_r, wo_nxt;
  logic [23:0] max_size_r;
  logic [7:0]  hdr_r [HDR_FIELDS];
  logic [7:0]  view [HDR_FIELDS];
  logic        accept;
  logic        sig_ok;
  logic [23:0] raw_len;
  logic [23:0] wo_inc;
  logic [31:0] sum_add;
  logic [31:0] total;

  assign accept = in_valid && space_ok;
  assign push   = accept;

  // Header bytes as seen this cycle, with the incoming byte forwarded
  always_comb begin
    for (int j = 0; j < HDR_FIELDS; j++) begin
      view[j] = (cnt_r == CW'(HDR_IDX[j])) ? in_rx_byte : hdr_r[j];
    end
  end

  assign sig_ok  = (view[F_SIG1] == CH_D) && (view[F_SIG2] == CH_F) &&
                   (view[F_SIG3] == CH_6) && (view[F_SIG6] == CH_DOT);
  assign raw_len = {view[F_LEN2], view[F_LEN1], view[F_LEN0]};
  assign wo_inc  = wo_r + 24'd1;
  assign sum_add = rsum_r + ((wo_r < len_r) ? {24'd0, in_rx_byte} : 32'd0);
  assign total   = (len_r == 24'd0) ? 32'd0 : sum_add;

  // Next state and result
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    hsum_nxt  = hsum_r;
    rsum_nxt  = rsum_r;
    wo_nxt    = wo_r;
    res       = '0;
    unique case (phase_r)
      PH_HEAD: begin
        res.status = ST_HDR_BYTE;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          if (sig_ok) begin
            len_nxt   = (raw_len > max_size_r) ? max_size_r : raw_len;
            hsum_nxt  = {view[F_SUM3], view[F_SUM2], view[F_SUM1], view[F_SUM0]};
            rsum_nxt  = '0;
            wo_nxt    = '0;
            phase_nxt = PH_DATA;
          end else begin
            res.status = ST_HDR_BAD;
            wo_nxt     = '0;
            cnt_nxt    = '0;
            phase_nxt  = PH_IDLE;
          end
        end
      end
      PH_DATA: begin
        res.store_valid  = 1'b1;
        res.store_offset = wo_r;
        res.store_data   = in_rx_byte;
        res.status       = ST_PAYLOAD;
        rsum_nxt         = sum_add;
        wo_nxt           = wo_inc;
        if ((wo_inc >= len_r) || (wo_inc == 24'd0)) begin
          res.status       = (total == hsum_r) ? ST_DONE_OK : ST_DONE_ERR;
          res.file_kind    = kind_code(hdr_r[F_KIND]);
          res.slot         = hdr_r[F_SLOT];
          res.expected_sum = hsum_r;
          res.computed_sum = total;
          rsum_nxt         = total;
          cnt_nxt          = '0;
          phase_nxt        = PH_IDLE;
        end
      end
      PH_IDLE: begin
        if (in_rx_byte == CH_START) begin
          cnt_nxt    = CW'(1);
          phase_nxt  = PH_HEAD;
          res.status = ST_HDR_BYTE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Advance state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      len_r   <= '0;
      hsum_r  <= '0;
      rsum_r  <= '0;
      wo_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      hsum_r  <= hsum_nxt;
      rsum_r  <= rsum_nxt;
      wo_r    <= wo_nxt;
    end
  end

  // Capture the header bytes that are used later
  always_ff @(posedge clk) begin
    if (accept && (phase_r == PH_HEAD)) begin
      for (int j = 0; j < HDR_FIELDS; j++) begin
        if (cnt_r == CW'(HDR_IDX[j])) begin
          hdr_r[j] <= in_rx_byte;
        end
      end
    end
  end

  // Hold the size limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MAX_SIZE_RST;
    end else if (cfg_valid) begin
      max_size_r <= cfg_max_size;
    end
  end

  `FDR_ASSERT_IMP(a_head_count, phase_r == PH_HEAD,
    (cnt_r != '0) && (cnt_r < CW'(HEADER_BYTES)), "header count out of range")
  `FDR_ASSERT_IMP(a_data_offset, phase_r == PH_DATA,
    (wo_r < len_r) || (wo_r == 24'd0), "write offset passed payload length")
  `FDR_ASSERT_NXT(a_head_end, accept && (phase_r == PH_HEAD) && (cnt_r == LAST),
    phase_r != PH_HEAD, "header did not end after its last byte")

endmodule

### hw/rtl/fdr_outbuf.sv
// Two-entry result buffer: output register plus skid register.
module fdr_outbuf import fdr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  fdr_result_t push_data,
  output logic        space_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output fdr_result_t out_data
);

  logic        out_valid_r;
  logic        skid_valid_r;
  fdr_result_t out_r;
  fdr_result_t skid_r;

  assign space_ok  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Control: drain the skid entry first, else take the new transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_r <= skid_valid_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

### hw/rtl/framed_download_receiver.sv
// Framed download receiver: one received byte in, one result out per byte, at
// a sustained rate of one byte per clock cycle while results drain. Each byte
// is parsed by the frame logic in the cycle it is accepted; its result goes
// into the output register or, while that is stalled, the skid register. A
// two-entry output buffer lets one more byte be taken while a result waits;
// the input stalls only when both entries are full. The size limit may be
// written at any time through the configuration channel, which is always
// ready; a length already latched from a header is kept. No memory is cleared
// after reset, so bytes are accepted from the first cycle after reset.
module framed_download_receiver import fdr_pkg::*; #(
  parameter int HEADER_BYTES = 32
) (
  input logic     clk,
  input logic     rst_n,
  fdr_in_if.sink  in_chan,
  fdr_out_if.source out_chan,
  fdr_cfg_if.sink cfg_chan
);

  logic        push;
  logic        space_ok;
  fdr_result_t res;
  fdr_result_t out_data;

  assign in_chan.ready  = space_ok;
  assign cfg_chan.ready = 1'b1;

  // Frame parsing
  fdr_core #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_rx_byte   (in_chan.rx_byte),
    .space_ok     (space_ok),
    .cfg_valid    (cfg_chan.valid),
    .cfg_max_size (cfg_chan.max_size),
    .push         (push),
    .res          (res)
  );

  // Result buffering
  fdr_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .space_ok  (space_ok),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  assign out_chan.status       = out_data.status;
  assign out_chan.store_valid  = out_data.store_valid;
  assign out_chan.store_offset = out_data.store_offset;
  assign out_chan.store_data   = out_data.store_data;
  assign out_chan.file_kind    = out_data.file_kind;
  assign out_chan.slot         = out_data.slot;
  assign out_chan.expected_sum = out_data.expected_sum;
  assign out_chan.computed_sum = out_data.computed_sum;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the framed download receiver: frames, noise and back-pressure.
module tb_top;
  import fdr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDR_LEN        = 32;
  localparam int RANDOM_ITEMS   = 700;
  localparam int STALL_CYCLES   = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_PRINTS     = 40;

  // Header byte positions
  localparam int POS_SIG_D   = 1;
  localparam int POS_SIG_F   = 2;
  localparam int POS_SIG_6   = 3;
  localparam int POS_SIG_DOT = 6;
  localparam int POS_KIND    = 10;
  localparam int POS_SLOT    = 11;
  localparam int POS_LEN     = 12;
  localparam int POS_SUM     = 16;

  logic clk;
  logic rst_n;

  fdr_in_if  in_ch ();
  fdr_out_if out_ch ();
  fdr_cfg_if cfg_ch ();

  framed_download_receiver #(.HEADER_BYTES(HDR_LEN)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  // Frame tracker state, kept in step with accepted bytes
  phase_t          fr_phase;
  int unsigned     hdr_cnt;
  logic [7:0]      hdr_buf [HDR_LEN];
  logic [23:0]     pay_len;
  logic [31:0]     hdr_sum;
  logic [31:0]     pay_sum;
  logic [23:0]     wr_off;
  logic [23:0]     size_limit;

  fdr_result_t     pending_results [$];
  int              taken_cnt = 0;
  int              result_cnt = 0;
  int              err_count = 0;
  bit              stall_req = 1'b0;
  bit              full_rate = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the frame tracker by one byte and return the result it causes
  function automatic fdr_result_t predict_byte(input logic [7:0] b);
    fdr_result_t r;
    logic [23:0] len;
    logic [31:0] total;
    r = '0;
    r.status = ST_IGNORED;
    case (fr_phase)
      PH_HEAD: begin
        if (hdr_cnt < HDR_LEN) hdr_buf[hdr_cnt] = b;
        hdr_cnt++;
        r.status = ST_HDR_BYTE;
        if (hdr_cnt >= HDR_LEN) begin
          if (hdr_buf[POS_SIG_D] == CH_D && hdr_buf[POS_SIG_F] == CH_F &&
              hdr_buf[POS_SIG_6] == CH_6 && hdr_buf[POS_SIG_DOT] == CH_DOT) begin
            len = {hdr_buf[POS_LEN+2], hdr_buf[POS_LEN+1], hdr_buf[POS_LEN]};
            if (len > size_limit) len = size_limit;
            pay_len = len;
            hdr_sum = {hdr_buf[POS_SUM+3], hdr_buf[POS_SUM+2],
                       hdr_buf[POS_SUM+1], hdr_buf[POS_SUM]};
            pay_sum = '0;
            wr_off = '0;
            fr_phase = PH_DATA;
          end else begin
            r.status = ST_HDR_BAD;
            wr_off = '0;
            hdr_cnt = 0;
            fr_phase = PH_IDLE;
          end
        end
      end
      PH_DATA: begin
        r.store_valid = 1'b1;
        r.store_offset = wr_off;
        r.store_data = b;
        if (wr_off < pay_len) pay_sum += b;
        wr_off = wr_off + 24'd1;
        r.status = ST_PAYLOAD;
        if (wr_off >= pay_len || wr_off == 24'd0) begin
          // Zero length keeps the sum at zero even though one byte was taken
          total = (pay_len == 24'd0) ? 32'd0 : pay_sum;
          r.status = (total == hdr_sum) ? ST_DONE_OK : ST_DONE_ERR;
          case (hdr_buf[POS_KIND])
            HDR_KIND_IMAGE:  r.file_kind = KIND_IMAGE;
            HDR_KIND_IMAGE2: r.file_kind = KIND_IMAGE2;
            HDR_KIND_FONT:   r.file_kind = KIND_FONT;
            default:         r.file_kind = KIND_UNKNOWN;
          endcase
          r.slot = hdr_buf[POS_SLOT];
          r.expected_sum = hdr_sum;
          r.computed_sum = total;
          pay_sum = total;
          hdr_cnt = 0;
          fr_phase = PH_IDLE;
        end
      end
      default: begin
        if (b == CH_START) begin
          hdr_buf[0] = b;
          hdr_cnt = 1;
          fr_phase = PH_HEAD;
          r.status = ST_HDR_BYTE;
        end
      end
    endcase
    return r;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("MISMATCH result %0d %s: got %0h want %0h", result_cnt, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Compare each result transaction with the oldest expected one
  always @(posedge clk) begin : check_results
    fdr_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_ch.status, '0);
      end else begin
        want = pending_results.pop_front();
        check_field("status", out_ch.status, want.status);
        check_field("store_valid", out_ch.store_valid, want.store_valid);
        check_field("store_offset", out_ch.store_offset, want.store_offset);
        check_field("store_data", out_ch.store_data, want.store_data);
        check_field("file_kind", out_ch.file_kind, want.file_kind);
        check_field("slot", out_ch.slot, want.slot);
        check_field("expected_sum", out_ch.expected_sum, want.expected_sum);
        check_field("computed_sum", out_ch.computed_sum, want.computed_sum);
      end
      result_cnt++;
    end
  end

  // Drive result ready: random runs, a long hold-off on request, full rate on request
  initial begin : result_ready
    int run_left;
    bit level;
    int pick;
    out_ch.ready = 1'b0;
    run_left = 0;
    level = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        out_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_req = 1'b0;
        run_left = 0;
      end else if (full_rate) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 55) begin
            level = 1'b1;
            run_left = $urandom_range(1, 20);
          end else if (pick < 65) begin
            level = 1'b1;
            run_left = $urandom_range(50, 150);
          end else if (pick < 92) begin
            level = 1'b0;
            run_left = $urandom_range(1, 3);
          end else begin
            level = 1'b0;
            run_left = $urandom_range(15, 50);
          end
        end
        out_ch.ready <= level;
        run_left--;
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Offer one byte, hold it until taken, then record its expected result
  task automatic send_byte(input logic [7:0] b);
    fdr_result_t res;
    int gap;
    int pick;
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    res = predict_byte(b);
    pending_results.push_back(res);
    if (res.status != ST_IGNORED) taken_cnt++;
    gap = 0;
    if (!full_rate) begin
      pick = $urandom_range(0, 99);
      if (pick >= 95) gap = $urandom_range(10, 40);
      else if (pick >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all results, let the block settle, then write the size limit
  task automatic write_max_size(input logic [23:0] v);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_size <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    size_limit = v;
  endtask

  // Send one frame: start mark, header, then payload if the signature holds
  task automatic send_frame(input logic [23:0] size_field, input logic [7:0] kind_byte,
                            input bit sig_ok, input bit sum_ok,
                            input bit cfg_mid, input logic [23:0] mid_limit);
    logic [7:0]  hdr [HDR_LEN];
    logic [7:0]  payload [$];
    logic [23:0] eff;
    logic [31:0] psum;
    logic [31:0] esum;
    int n;
    int pos;
    // Flush any frame left open by noise
    while (fr_phase != PH_IDLE) send_byte(8'($urandom_range(0, 255)));
    eff = (size_field > size_limit) ? size_limit : size_field;
    n = (eff == 24'd0) ? 1 : int'(eff);
    psum = '0;
    for (int i = 0; i < n; i++) begin
      payload.push_back(8'($urandom_range(0, 255)));
      if (eff != 24'd0) psum += payload[i];
    end
    esum = sum_ok ? psum : $urandom();
    for (int i = 0; i < HDR_LEN; i++) hdr[i] = 8'($urandom_range(0, 255));
    hdr[0] = CH_START;
    hdr[POS_SIG_D] = CH_D;
    hdr[POS_SIG_F] = CH_F;
    hdr[POS_SIG_6] = CH_6;
    hdr[POS_SIG_DOT] = CH_DOT;
    hdr[POS_KIND] = kind_byte;
    hdr[POS_LEN] = size_field[7:0];
    hdr[POS_LEN+1] = size_field[15:8];
    hdr[POS_LEN+2] = size_field[23:16];
    for (int i = 0; i < 4; i++) hdr[POS_SUM+i] = esum[8*i +: 8];
    if (!sig_ok) begin
      case ($urandom_range(0, 3))
        0:       pos = POS_SIG_D;
        1:       pos = POS_SIG_F;
        2:       pos = POS_SIG_6;
        default: pos = POS_SIG_DOT;
      endcase
      hdr[pos] = hdr[pos] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < HDR_LEN; i++) send_byte(hdr[i]);
    if (sig_ok) begin
      if (cfg_mid) write_max_size(mid_limit);
      foreach (payload[i]) send_byte(payload[i]);
    end
  endtask

  function automatic logic [7:0] pick_kind();
    case ($urandom_range(0, 3))
      0:       return HDR_KIND_IMAGE;
      1:       return HDR_KIND_IMAGE2;
      2:       return HDR_KIND_FONT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Bytes in idle that are not a start mark give an ignored result
  task automatic test_ignored_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_START - 8'd1);
    send_byte(CH_START + 8'd1);
  endtask

  // A good frame under the reset limit, then a zero-length frame
  task automatic test_reset_limit_and_zero_length();
    send_frame(24'd10, HDR_KIND_IMAGE, 1'b1, 1'b1, 1'b0, '0);
    send_frame(24'd0, HDR_KIND_IMAGE, 1'b1, 1'b1, 1'b0, '0);
  endtask

  task automatic test_rejected_header();
    send_frame(24'd3, HDR_KIND_FONT, 1'b0, 1'b1, 1'b0, '0);
  endtask

  // Oversize header lengths clamp to limits of 3 and 0; the largest limit passes a short length
  task automatic test_oversize_clamp();
    write_max_size(24'd3);
    send_frame(24'hFFFFFF, HDR_KIND_IMAGE2, 1'b1, 1'b1, 1'b0, '0);
    write_max_size(24'd0);
    send_frame(24'd5, HDR_KIND_FONT, 1'b1, 1'b1, 1'b0, '0);
    write_max_size(24'hFFFFFF);
    send_frame(24'd2, 8'h99, 1'b1, 1'b0, 1'b0, '0);
  endtask

  // A limit written after the header leaves the latched length alone
  task automatic test_limit_write_mid_frame();
    send_frame(24'd4, HDR_KIND_IMAGE, 1'b1, 1'b1, 1'b1, 24'd1);
  endtask

  // Hold off the result side while bytes keep coming so the input stalls
  task automatic test_back_pressure();
    write_max_size(24'hFFFFFF);
    full_rate = 1'b1;
    stall_req = 1'b1;
    send_frame(24'd20, HDR_KIND_IMAGE2, 1'b1, 1'b1, 1'b0, '0);
    full_rate = 1'b0;
  endtask

  // Random frames, broken frames and noise over several size limits
  task automatic test_random_frames();
    logic [23:0] limits [5];
    logic [23:0] size_field;
    int goal;
    int pick;
    int n;
    limits[0] = 24'($urandom_range(1, 40));
    limits[1] = 24'd0;
    limits[2] = 24'hFFFFFF;
    limits[3] = 24'($urandom_range(0, 6));
    limits[4] = MAX_SIZE_RST;
    foreach (limits[p]) begin
      write_max_size(limits[p]);
      goal = taken_cnt + RANDOM_ITEMS / 5;
      while (taken_cnt < goal) begin
        pick = $urandom_range(0, 99);
        if (size_limit <= 24'd40 && $urandom_range(0, 2) == 0)
          size_field = 24'($urandom());
        else
          size_field = 24'($urandom_range(0, 24));
        if (pick < 12) begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 24) begin
          send_frame(size_field, pick_kind(), 1'b0, 1'b1, 1'b0, '0);
        end else begin
          send_frame(size_field, pick_kind(), 1'b1, $urandom_range(0, 3) != 0, 1'b0, '0);
        end
      end
    end
  endtask

  // Main sequence
  initial begin : stimulus
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_size = '0;
    rst_n = 1'b0;
    fr_phase = PH_IDLE;
    hdr_cnt = 0;
    pay_len = '0;
    hdr_sum = '0;
    pay_sum = '0;
    wr_off = '0;
    size_limit = MAX_SIZE_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_ignored_bytes();
    test_reset_limit_and_zero_length();
    test_rejected_header();
    test_oversize_clamp();
    test_limit_write_mid_frame();
    test_back_pressure();
    test_random_frames();

    // Drain and let any stray result show up
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### framed_download_receiver.f
+incdir+hw/rtl
hw/rtl/fdr_pkg.sv
hw/rtl/fdr_if.sv
hw/rtl/fdr_core.sv
hw/rtl/fdr_outbuf.sv
hw/rtl/framed_download_receiver.sv
tb/tb_top.sv
